>>> rtl/core/cmdtok_pkg.sv
// Package for the command line tokenizer.
// Holds byte codes, result kinds and the result record type; no dependencies.
package cmdtok_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   localparam logic KIND_ARG_BYTE = 1'b0;
   localparam logic KIND_LINE_END = 1'b1;

   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       starts_argument;
      logic [4:0] arg_index;
      logic [5:0] arg_count;
      logic       last;
   } rsp_type;

endpackage

>>> rtl/core/command_line_tokenizer.sv
// Command line tokenizer top level: byte input stage, tokenizer logic, result queue.
// Depends on cmdtok_pkg.
//
// Usage:
//   req_* carries one console byte per request. A newline ends a line, a zero
//   byte is dropped. rsp_* carries argument bytes (tuser = 0) and line-end
//   events (tuser = 1); tlast marks the final result caused by one input byte.
//   A byte is registered on acceptance and decoded once the result queue has room,
//   which writes its zero, one or two results into a four-entry result queue.
//   Results are registered in the queue; rsp_tvalid shows a non-empty queue.
//   Throughput is one byte per cycle while the queue has room; a two-result
//   byte (a kept backslash, or a held backslash before newline) needs two transfers.
//   The decode stage fires only while the queue has two free entries, so a
//   stalled receiver backs up into req_tready after at most four results
//   plus the one byte in the input register.
//   Reset clears the queue, the input register and the line state (start of
//   a new line, no arguments seen). No clearing pass is needed.
module command_line_tokenizer #(
   parameter int MAX_ARGS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] input_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [cmdtok_pkg::RSP_DATA_W-1:0] rsp_tdata, // [7:0] data_byte,
                                    // [8] starts_argument, [13:9] arg_index,
                                    // [19:14] arg_count, [23:20] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // last
);
   import cmdtok_pkg::*;

   localparam int CNT_NEED = $clog2(MAX_ARGS + 1);
   localparam int CNT_W    = (CNT_NEED > 6) ? CNT_NEED : 6;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ARGS);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // line state
   logic [7:0]       prev_ff, prev_in;
   logic [7:0]       pprev_ff, pprev_in;
   logic [CNT_W-1:0] args_ff, args_in;
   logic             held_ff, held_in;
   logic             held_starts_ff, held_starts_in;
   logic             stopped_ff, stopped_in;

   // result queue
   rsp_type    q_mem_ff [4];
   logic [1:0] q_wr_ff, q_wr_in;
   logic [1:0] q_rd_ff, q_rd_in;
   logic [2:0] q_cnt_ff, q_cnt_in;

   logic       fire, pop;
   logic [1:0] n_push;
   rsp_type    r0, r1;
   logic [7:0] b;
   logic       b_blank, b_sp_tab, prev_blank, fresh, lim, proceed;
   logic       held_eff, stopped_eff;
   logic [CNT_W-1:0] args_n, idx_full;

   assign fire       = in_valid_ff && (q_cnt_ff <= 3'd2);
   assign req_tready = !in_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;

   assign rsp_tvalid = (q_cnt_ff != 3'd0);
   assign rsp_tuser  = q_mem_ff[q_rd_ff].kind;
   assign rsp_tlast  = q_mem_ff[q_rd_ff].last;
   assign rsp_tdata  = {4'd0, q_mem_ff[q_rd_ff].arg_count, q_mem_ff[q_rd_ff].arg_index,
                        q_mem_ff[q_rd_ff].starts_argument, q_mem_ff[q_rd_ff].data_byte};

   always_comb begin
      b          = in_byte_ff;
      b_sp_tab   = (b == CHAR_SPACE) || (b == CHAR_TAB);
      b_blank    = b_sp_tab || (b == CHAR_CR);
      prev_blank = (prev_ff == CHAR_SPACE) || (prev_ff == CHAR_TAB) || (prev_ff == CHAR_CR);
      lim        = (args_ff < MAX_CNT);
      fresh      = 1'b0;
      proceed    = 1'b1;

      in_valid_in    = req_tready ? req_tvalid : in_valid_ff;
      in_byte_in     = (req_tready && req_tvalid) ? req_tdata : in_byte_ff;
      prev_in        = prev_ff;
      pprev_in       = pprev_ff;
      args_in        = args_ff;
      held_in        = held_ff;
      held_starts_in = held_starts_ff;
      stopped_in     = stopped_ff;
      n_push         = 2'd0;
      r0             = '0;
      r1             = '0;
      args_n         = args_ff;
      held_eff       = held_ff;
      stopped_eff    = stopped_ff;
      idx_full       = args_ff - CNT_W'(1);

      if (fire && (b != CHAR_NUL)) begin
         if (b == CHAR_NEWLINE) begin
            r0.kind      = KIND_LINE_END;
            r0.arg_count = args_ff[5:0];
            r0.last      = 1'b1;
            if (held_ff) begin
               r1        = r0;
               r0        = '0;
               r0.kind   = KIND_ARG_BYTE;
               r0.data_byte       = CHAR_BACKSLASH;
               r0.starts_argument = held_starts_ff;
               r0.arg_index       = idx_full[4:0];
               n_push    = 2'd2;
            end else begin
               n_push    = 2'd1;
            end
            prev_in        = CHAR_SPACE;
            pprev_in       = CHAR_SPACE;
            args_in        = '0;
            held_in        = 1'b0;
            held_starts_in = 1'b0;
            stopped_in     = 1'b0;
         end else begin
            if (lim) begin
               if (b_blank && (prev_ff != CHAR_BACKSLASH)) begin
                  proceed = 1'b0;
               end else begin
                  fresh = prev_blank && (pprev_ff != CHAR_BACKSLASH);
                  if (fresh) begin
                     args_n      = args_ff + CNT_W'(1);
                     stopped_eff = 1'b0;
                     held_eff    = 1'b0;
                  end
               end
               pprev_in = prev_ff;
               prev_in  = b;
            end
            idx_full = args_n - CNT_W'(1);
            if (proceed && (args_n != '0)) begin
               args_in        = args_n;
               held_in        = held_eff;
               stopped_in     = stopped_eff;
               r0.kind        = KIND_ARG_BYTE;
               r0.arg_index   = idx_full[4:0];
               r1.kind        = KIND_ARG_BYTE;
               r1.arg_index   = idx_full[4:0];
               if (held_eff) begin
                  held_in        = 1'b0;
                  held_starts_in = 1'b0;
                  r0.starts_argument = held_starts_ff;
                  if (b_sp_tab) begin
                     r0.data_byte = b;
                     r0.last      = 1'b1;
                     n_push       = 2'd1;
                  end else begin
                     r0.data_byte = CHAR_BACKSLASH;
                     r1.data_byte = b;
                     r1.last      = 1'b1;
                     stopped_in   = 1'b1;
                     n_push       = 2'd2;
                  end
               end else if (!stopped_eff && (b == CHAR_BACKSLASH)) begin
                  held_in        = 1'b1;
                  held_starts_in = fresh;
               end else begin
                  r0.data_byte       = b;
                  r0.starts_argument = fresh;
                  r0.last            = 1'b1;
                  n_push             = 2'd1;
               end
            end else if (proceed) begin
               args_in = args_n;
            end
         end
      end

      q_wr_in  = q_wr_ff + n_push;
      q_rd_in  = q_rd_ff + {1'b0, pop};
      q_cnt_in = q_cnt_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         prev_ff        <= CHAR_SPACE;
         pprev_ff       <= CHAR_SPACE;
         args_ff        <= '0;
         held_ff        <= 1'b0;
         held_starts_ff <= 1'b0;
         stopped_ff     <= 1'b0;
         q_wr_ff        <= 2'd0;
         q_rd_ff        <= 2'd0;
         q_cnt_ff       <= 3'd0;
      end else begin
         in_valid_ff    <= in_valid_in;
         prev_ff        <= prev_in;
         pprev_ff       <= pprev_in;
         args_ff        <= args_in;
         held_ff        <= held_in;
         held_starts_ff <= held_starts_in;
         stopped_ff     <= stopped_in;
         q_wr_ff        <= q_wr_in;
         q_rd_ff        <= q_rd_in;
         q_cnt_ff       <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (n_push != 2'd0) begin
         q_mem_ff[q_wr_ff] <= r0;
      end
      if (n_push == 2'd2) begin
         q_mem_ff[q_wr_ff + 2'd1] <= r1;
      end
   end

endmodule

>>> test/command_line_tokenizer_checker.sv
`timescale 1ns / 100ps
// Checker for the command line tokenizer: watches both stream channels, predicts
// the argument bytes and line ends of each accepted request and compares results.
// Depends on cmdtok_pkg.
module command_line_tokenizer_checker #(
   parameter int MAX_ARGS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [cmdtok_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic       rsp_tuser,
   input  logic       rsp_tlast,
   output int         failures,
   output int         pending
);
   import cmdtok_pkg::*;

   rsp_type    expected_tokens[$];
   logic [7:0] last_byte;
   logic [7:0] byte_before_last;
   int         args_in_line;
   logic       backslash_waiting;
   logic       waiting_starts;
   logic       escapes_off;
   int         fail_total = 0;

   function automatic logic separator_char(input logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR;
   endfunction

   function automatic rsp_type arg_token(input logic [7:0] b, input logic first);
      rsp_type t;
      t = '0;
      t.kind = KIND_ARG_BYTE;
      t.data_byte = b;
      t.starts_argument = first;
      t.arg_index = 5'(args_in_line - 1);
      return t;
   endfunction

   task automatic clear_line();
      last_byte = CHAR_SPACE;
      byte_before_last = CHAR_SPACE;
      args_in_line = 0;
      backslash_waiting = 1'b0;
      waiting_starts = 1'b0;
      escapes_off = 1'b0;
   endtask

   task automatic tokenize_byte(input logic [7:0] b);
      rsp_type found[2];
      int      n;
      logic    fresh;
      n = 0;
      fresh = 1'b0;
      if (b == CHAR_NUL) return;
      if (b == CHAR_NEWLINE) begin
         if (backslash_waiting) begin
            found[n] = arg_token(CHAR_BACKSLASH, waiting_starts);
            n++;
         end
         found[n] = '0;
         found[n].kind = KIND_LINE_END;
         found[n].arg_count = 6'(args_in_line);
         n++;
         clear_line();
      end else begin
         if (args_in_line < MAX_ARGS) begin
            if (separator_char(b) && last_byte != CHAR_BACKSLASH) begin
               byte_before_last = last_byte;
               last_byte = b;
               return;
            end
            fresh = separator_char(last_byte) && byte_before_last != CHAR_BACKSLASH;
            if (fresh) begin
               args_in_line++;
               escapes_off = 1'b0;
               backslash_waiting = 1'b0;
            end
            byte_before_last = last_byte;
            last_byte = b;
         end
         if (args_in_line == 0) return;
         if (backslash_waiting) begin
            backslash_waiting = 1'b0;
            if (b == CHAR_SPACE || b == CHAR_TAB) begin
               found[n] = arg_token(b, waiting_starts);
               n++;
            end else begin
               found[n] = arg_token(CHAR_BACKSLASH, waiting_starts);
               found[n + 1] = arg_token(b, 1'b0);
               n += 2;
               escapes_off = 1'b1;
            end
            waiting_starts = 1'b0;
         end else if (!escapes_off && b == CHAR_BACKSLASH) begin
            backslash_waiting = 1'b1;
            waiting_starts = fresh;
         end else begin
            found[n] = arg_token(b, fresh);
            n++;
         end
      end
      if (n > 0) found[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_tokens.push_back(found[i]);
   endtask

   function automatic int field_differs(input string name, input int want, input int got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      if (reset) begin
         clear_line();
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready) tokenize_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b",
                        $time, rsp_tdata, rsp_tuser);
               fail_total++;
            end else begin
               want = expected_tokens.pop_front();
               bad = field_differs("kind", int'(want.kind), int'(rsp_tuser))
                   + field_differs("data_byte", int'(want.data_byte), int'(rsp_tdata[7:0]))
                   + field_differs("starts_argument", int'(want.starts_argument),
                                   int'(rsp_tdata[8]))
                   + field_differs("arg_index", int'(want.arg_index), int'(rsp_tdata[13:9]))
                   + field_differs("arg_count", int'(want.arg_count), int'(rsp_tdata[19:14]))
                   + field_differs("padding", 0, int'(rsp_tdata[23:20]))
                   + field_differs("last", int'(want.last), int'(rsp_tlast));
               if (bad != 0) fail_total++;
            end
         end
      end
      failures <= fail_total;
      pending <= expected_tokens.size();
   end

endmodule

>>> test/command_line_tokenizer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the command line tokenizer: clock, reset, request and result
// stimulus with random gaps, and the verdict. Depends on cmdtok_pkg and the checker.
module command_line_tokenizer_tb;
   import cmdtok_pkg::*;

   localparam int MAX_ARGS     = 32;
   localparam int RANDOM_BYTES = 400;
   localparam int CYCLE_LIMIT  = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;
   int         failures;
   int         pending;
   int         cycles = 0;
   logic       gaps_off = 1'b0;
   logic [7:0] line_bytes[$];

   // empty line, ignored zero, escapes of every kind, held backslash at newline
   logic [7:0] directed_bytes[21] = '{
      CHAR_NEWLINE, CHAR_NUL,
      8'h61, 8'hFF, 8'h80, CHAR_SPACE, CHAR_BACKSLASH, CHAR_SPACE, 8'h62, CHAR_TAB,
      CHAR_BACKSLASH, CHAR_CR, CHAR_BACKSLASH, 8'h78, CHAR_SPACE, CHAR_BACKSLASH,
      CHAR_NEWLINE,
      CHAR_BACKSLASH, CHAR_TAB, 8'h01, CHAR_NEWLINE
   };

   always #5 clock = ~clock;

   command_line_tokenizer #(.MAX_ARGS(MAX_ARGS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   command_line_tokenizer_checker #(.MAX_ARGS(MAX_ARGS)) checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .failures(failures), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int stall;
      int run;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = gaps_off ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [7:0] content_byte();
      int         r;
      logic [7:0] b;
      r = $urandom_range(0, 11);
      if (r < 2) return CHAR_BACKSLASH;
      if (r == 2) begin
         do b = 8'($urandom_range(1, 255)); while (b == CHAR_NEWLINE);
         return b;
      end
      if (r == 3) return CHAR_NUL;
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return CHAR_TAB;
         1: return CHAR_CR;
         default: return CHAR_SPACE;
      endcase
   endfunction

   task automatic add_separators();
      repeat ($urandom_range(1, 3)) line_bytes.push_back(blank_byte());
   endtask

   task automatic add_argument(input int len);
      repeat (len) begin
         if ($urandom_range(0, 9) == 0) begin
            line_bytes.push_back(CHAR_BACKSLASH);
            line_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
         end else begin
            line_bytes.push_back(content_byte());
         end
      end
   endtask

   task automatic build_line(input int line_no);
      int args;
      int max_len;
      line_bytes.delete();
      if (line_no % 8 == 3) begin
         args = $urandom_range(MAX_ARGS + 1, MAX_ARGS + 8);
         max_len = 2;
      end else if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
         args = 0;
         max_len = 1;
      end else begin
         args = $urandom_range(0, 6);
         max_len = 8;
      end
      if ($urandom_range(0, 2) == 0) add_separators();
      for (int i = 0; i < args; i++) begin
         if (i > 0) add_separators();
         add_argument($urandom_range(1, max_len));
      end
      if ($urandom_range(0, 3) == 0) add_separators();
      if ($urandom_range(0, 5) == 0) line_bytes.push_back(CHAR_BACKSLASH);
      line_bytes.push_back(CHAR_NEWLINE);
   endtask

   initial begin
      int sent;
      int line_no;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      hold_until_drained();
      sent = 0;
      line_no = 0;
      while (sent < RANDOM_BYTES) begin
         gaps_off = ($urandom_range(0, 4) == 0);
         if (line_no == 5) hold_until_drained();
         build_line(line_no);
         foreach (line_bytes[i]) begin
            send_byte(line_bytes[i]);
            if (line_bytes[i] != CHAR_NUL) sent++;
         end
         line_no++;
      end
      hold_until_drained();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
